FILE: hdl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, cofactor index tables and types of the 3x3 inverse unit.
// ----------------------------------------------------------------------------
package m3i_pkg;

	// Entry, product, cofactor, determinant and inverse widths.
	localparam int ENT_W = 16;
	localparam int PRD_W = 32;
	localparam int COF_W = 33;
	localparam int DTM_W = 49;
	localparam int DSUM_W = 51;
	localparam int DET_W = 49;
	localparam int INV_W = 32;

	// Scale of the unit value 1.0 applied to each cofactor before division.
	localparam int UNIT_SHIFT = 24;

	// Divider: magnitudes, and one quotient bit per stage plus an overflow bit.
	localparam int NUM_W = 32 + UNIT_SHIFT;
	localparam int DEN_W = 48;
	localparam int QUO_W = 34;
	localparam int DIV_STAGES = QUO_W;
	localparam int TRIAL_W = DEN_W + QUO_W;

	localparam int N_ENT = 9;

	// Cofactor k of the inverse (row-major) is m[PA]*m[PB] - m[PC]*m[PD],
	// with the sign of the adjugate folded into the operand order.
	localparam int unsigned PA [N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int unsigned PB [N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int unsigned PC [N_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int unsigned PD [N_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	// Side data that travels with an item through the divider.
	typedef struct packed {
		logic signed [DET_W-1:0] det;
		logic                    singular;
		logic [N_ENT-1:0]        neg;
	} side_t;

endpackage

FILE: hdl/m3i_if.sv
// ----------------------------------------------------------------------------
// m3i_if
// Valid/ready channels for the input matrix word and the result word.
// ----------------------------------------------------------------------------
interface m3i_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

	modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		input ready);
	modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		output ready);
endinterface

interface m3i_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] inv_00, inv_01, inv_02, inv_10, inv_11, inv_12;
	logic signed [31:0] inv_20, inv_21, inv_22;
	logic signed [48:0] determinant;
	logic singular;
	logic saturated;

	modport source (output valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
		inv_20, inv_21, inv_22, determinant, singular, saturated, input ready);
	modport sink (input valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
		inv_20, inv_21, inv_22, determinant, singular, saturated, output ready);
endinterface

FILE: hdl/matrix3x3_inverse_unit.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit
// Inverse of a signed Q8.8 3x3 matrix by the adjugate, Q16.16 results.
// ----------------------------------------------------------------------------
// One matrix word is accepted per clock while no result word waits at the
// output; the throughput is then one word a cycle. Six stages form the products,
// the cofactors, the determinant and the magnitudes; a 34-stage divider, one
// quotient bit per stage across nine lanes, sets most of the latency; a last
// stage applies sign and saturation. The whole pipeline holds while a finished
// result word waits at the output, so nothing is lost or repeated under stall.
// Entries are truncated toward zero and clipped to 32 bits, which raises
// saturated; a zero determinant returns zero entries with singular set.
module matrix3x3_inverse_unit (
	input  logic     clk,
	input  logic     arst_n,
	m3i_in_if.sink   mat,
	m3i_out_if.source res
);

	localparam int N = m3i_pkg::N_ENT;

	logic en;

	logic                              v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [m3i_pkg::ENT_W-1:0]  m_s1 [N];
	logic signed [m3i_pkg::PRD_W-1:0]  pa_s2 [N];
	logic signed [m3i_pkg::PRD_W-1:0]  pb_s2 [N];
	logic signed [m3i_pkg::ENT_W-1:0]  r0_s2 [3];
	logic signed [m3i_pkg::COF_W-1:0]  cof_s3 [N];
	logic signed [m3i_pkg::ENT_W-1:0]  r0_s3 [3];
	logic signed [m3i_pkg::DTM_W-1:0]  dt_s4 [3];
	logic signed [m3i_pkg::COF_W-1:0]  cof_s4 [N];
	logic signed [m3i_pkg::DSUM_W-1:0] det_s5;
	logic signed [m3i_pkg::COF_W-1:0]  cof_s5 [N];
	logic [m3i_pkg::NUM_W-1:0]         nmag_s6 [N];
	logic [m3i_pkg::DEN_W-1:0]         dmag_s6;
	m3i_pkg::side_t                    side_s6;

	logic                          dv_vld;
	logic [m3i_pkg::QUO_W-1:0]     dv_quo [N];
	m3i_pkg::side_t                dv_side;

	logic                          v_s40;
	logic signed [m3i_pkg::INV_W-1:0] inv_s40 [N];
	logic signed [m3i_pkg::DET_W-1:0] det_s40;
	logic                          sing_s40;
	logic                          sat_s40;

	// The pipeline advances unless a result word is stuck at the output.
	assign en = !v_s40 || res.ready;
	assign mat.ready = en;

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= mat.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Front stages: capture, products, cofactors, determinant terms, sum, magnitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= '{mat.a00, mat.a01, mat.a02, mat.a10, mat.a11, mat.a12,
				mat.a20, mat.a21, mat.a22};

			for (int k = 0; k < N; k++) begin
				pa_s2[k] <= m_s1[m3i_pkg::PA[k]] * m_s1[m3i_pkg::PB[k]];
				pb_s2[k] <= m_s1[m3i_pkg::PC[k]] * m_s1[m3i_pkg::PD[k]];
			end
			for (int j = 0; j < 3; j++) begin
				r0_s2[j] <= m_s1[j];
			end

			for (int k = 0; k < N; k++) begin
				cof_s3[k] <= m3i_pkg::COF_W'(pa_s2[k]) - m3i_pkg::COF_W'(pb_s2[k]);
			end
			r0_s3 <= r0_s2;

			// First-row expansion uses column zero of the adjugate, the cofactors of row zero.
			dt_s4[0] <= r0_s3[0] * cof_s3[0];
			dt_s4[1] <= r0_s3[1] * cof_s3[3];
			dt_s4[2] <= r0_s3[2] * cof_s3[6];
			cof_s4 <= cof_s3;

			det_s5 <= m3i_pkg::DSUM_W'(dt_s4[0]) + m3i_pkg::DSUM_W'(dt_s4[1])
				+ m3i_pkg::DSUM_W'(dt_s4[2]);
			cof_s5 <= cof_s4;

			// Magnitudes for the divider; a zero divisor is replaced by one.
			side_s6.det <= m3i_pkg::DET_W'(det_s5);
			side_s6.singular <= (det_s5 == '0);
			if (det_s5 == '0) begin
				dmag_s6 <= m3i_pkg::DEN_W'(1);
			end else if (det_s5[m3i_pkg::DSUM_W-1]) begin
				dmag_s6 <= m3i_pkg::DEN_W'(-det_s5);
			end else begin
				dmag_s6 <= m3i_pkg::DEN_W'(det_s5);
			end
			for (int k = 0; k < N; k++) begin
				side_s6.neg[k] <= cof_s5[k][m3i_pkg::COF_W-1]
					^ det_s5[m3i_pkg::DSUM_W-1];
				if (cof_s5[k][m3i_pkg::COF_W-1]) begin
					nmag_s6[k] <= {32'(-cof_s5[k]), m3i_pkg::UNIT_SHIFT'(0)};
				end else begin
					nmag_s6[k] <= {32'(cof_s5[k]), m3i_pkg::UNIT_SHIFT'(0)};
				end
			end
		end
	end

	m3i_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s6),
		.nmag     (nmag_s6),
		.dmag     (dmag_s6),
		.side_in  (side_s6),
		.out_vld  (dv_vld),
		.quo      (dv_quo),
		.side_out (dv_side)
	);

	// Output stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s40 <= 1'b0;
		end else if (en) begin
			v_s40 <= dv_vld;
		end
	end

	// Sign, saturation and the singular case.
	always_ff @(posedge clk) begin
		logic any_sat;
		logic clip;
		if (en) begin
			any_sat = 1'b0;
			for (int k = 0; k < N; k++) begin
				if (dv_side.neg[k]) begin
					clip = dv_quo[k][33] || (dv_quo[k][32:0] > 33'h080000000);
				end else begin
					clip = dv_quo[k][33] || (dv_quo[k][32:0] > 33'h07FFFFFFF);
				end
				if (dv_side.singular) begin
					inv_s40[k] <= '0;
				end else if (clip) begin
					inv_s40[k] <= dv_side.neg[k] ? 32'sh80000000 : 32'sh7FFFFFFF;
					any_sat = 1'b1;
				end else if (dv_side.neg[k]) begin
					inv_s40[k] <= -dv_quo[k][31:0];
				end else begin
					inv_s40[k] <= dv_quo[k][31:0];
				end
			end
			det_s40 <= dv_side.det;
			sing_s40 <= dv_side.singular;
			sat_s40 <= any_sat && !dv_side.singular;
		end
	end

	assign res.valid = v_s40;
	assign res.inv_00 = inv_s40[0];
	assign res.inv_01 = inv_s40[1];
	assign res.inv_02 = inv_s40[2];
	assign res.inv_10 = inv_s40[3];
	assign res.inv_11 = inv_s40[4];
	assign res.inv_12 = inv_s40[5];
	assign res.inv_20 = inv_s40[6];
	assign res.inv_21 = inv_s40[7];
	assign res.inv_22 = inv_s40[8];
	assign res.determinant = det_s40;
	assign res.singular = sing_s40;
	assign res.saturated = sat_s40;

	// A singular result carries a zero determinant and zero entries.
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.singular |-> res.determinant == '0 && res.inv_00 == '0
			&& res.inv_11 == '0 && res.inv_22 == '0 && !res.saturated)
		else $error("singular result with nonzero fields");

	// A nonzero determinant never reports singular.
	a_det_nonsing: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.determinant != '0 |-> !res.singular)
		else $error("singular flag with nonzero determinant");

	// The front stages hold while the output is stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s6) && $stable(dv_vld))
		else $error("pipeline moved during stall");

	// Ready follows the output stage alone.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		mat.ready == (!res.valid || res.ready))
		else $error("input ready out of step with output stage");

endmodule

FILE: hdl/m3i_div.sv
// ----------------------------------------------------------------------------
// m3i_div
// Pipelined restoring divider, nine lanes sharing one divisor, one bit a stage.
// ----------------------------------------------------------------------------
module m3i_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [m3i_pkg::NUM_W-1:0]    nmag [m3i_pkg::N_ENT],
	input  logic [m3i_pkg::DEN_W-1:0]    dmag,
	input  m3i_pkg::side_t               side_in,
	output logic                         out_vld,
	output logic [m3i_pkg::QUO_W-1:0]    quo [m3i_pkg::N_ENT],
	output m3i_pkg::side_t               side_out
);

	logic                      vld_s  [m3i_pkg::DIV_STAGES];
	logic [m3i_pkg::NUM_W-1:0] rem_s  [m3i_pkg::DIV_STAGES][m3i_pkg::N_ENT];
	logic [m3i_pkg::QUO_W-1:0] quo_s  [m3i_pkg::DIV_STAGES][m3i_pkg::N_ENT];
	logic [m3i_pkg::DEN_W-1:0] den_s  [m3i_pkg::DIV_STAGES];
	m3i_pkg::side_t            side_s [m3i_pkg::DIV_STAGES];

	for (genvar k = 0; k < m3i_pkg::DIV_STAGES; k++) begin : g_stg
		localparam int SH = m3i_pkg::DIV_STAGES - 1 - k;

		logic                      vld_c;
		logic [m3i_pkg::NUM_W-1:0] rem_c [m3i_pkg::N_ENT];
		logic [m3i_pkg::QUO_W-1:0] quo_c [m3i_pkg::N_ENT];
		logic [m3i_pkg::DEN_W-1:0] den_c;
		m3i_pkg::side_t            side_c;
		logic [m3i_pkg::TRIAL_W-1:0] trial;

		// Stage input: the ports for the first stage, else the previous stage.
		if (k == 0) begin : g_first
			always_comb begin
				vld_c = in_vld;
				den_c = dmag;
				side_c = side_in;
				for (int l = 0; l < m3i_pkg::N_ENT; l++) begin
					rem_c[l] = nmag[l];
					quo_c[l] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				vld_c = vld_s[k-1];
				den_c = den_s[k-1];
				side_c = side_s[k-1];
				for (int l = 0; l < m3i_pkg::N_ENT; l++) begin
					rem_c[l] = rem_s[k-1][l];
					quo_c[l] = quo_s[k-1][l];
				end
			end
		end

		assign trial = m3i_pkg::TRIAL_W'(den_c) << SH;

		// Valid bit of this stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_c;
			end
		end

		// One trial subtraction per lane; the outcome is the next quotient bit.
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_c;
				side_s[k] <= side_c;
				for (int l = 0; l < m3i_pkg::N_ENT; l++) begin
					if (m3i_pkg::TRIAL_W'(rem_c[l]) >= trial) begin
						rem_s[k][l] <= rem_c[l] - trial[m3i_pkg::NUM_W-1:0];
						quo_s[k][l] <= {quo_c[l][m3i_pkg::QUO_W-2:0], 1'b1};
					end else begin
						rem_s[k][l] <= rem_c[l];
						quo_s[k][l] <= {quo_c[l][m3i_pkg::QUO_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_vld = vld_s[m3i_pkg::DIV_STAGES-1];
	assign quo = quo_s[m3i_pkg::DIV_STAGES-1];
	assign side_out = side_s[m3i_pkg::DIV_STAGES-1];

endmodule

FILE: sim/tb_matrix3x3_inverse_unit.sv
// ----------------------------------------------------------------------------
// tb_matrix3x3_inverse_unit
// Self-checking bench for the 3x3 adjugate inverse unit: directed and random
// matrices are sent with bursty valid, results are taken with random stalls
// and one long hold-off, and every result word is checked field by field.
// ----------------------------------------------------------------------------

// One result word as seen on the output channel.
typedef struct {
	logic signed [31:0] inv [9];
	logic signed [48:0] det;
	logic               sing;
	logic               sat;
} inv_word_t;

class m3i_inverse_board;
	inv_word_t pending[$];
	int        errors;

	function new();
		errors = 0;
	endfunction

	// Exact adjugate inverse with truncating division and 32-bit clipping.
	function void note_matrix(logic signed [15:0] m [9]);
		longint    mm [9];
		longint    cof [9];
		longint    d;
		longint    q;
		inv_word_t w;
		for (int k = 0; k < 9; k++) mm[k] = m[k];
		cof[0] = mm[4]*mm[8] - mm[5]*mm[7];
		cof[1] = -(mm[1]*mm[8] - mm[2]*mm[7]);
		cof[2] = mm[1]*mm[5] - mm[2]*mm[4];
		cof[3] = -(mm[3]*mm[8] - mm[5]*mm[6]);
		cof[4] = mm[0]*mm[8] - mm[2]*mm[6];
		cof[5] = -(mm[0]*mm[5] - mm[2]*mm[3]);
		cof[6] = mm[3]*mm[7] - mm[4]*mm[6];
		cof[7] = -(mm[0]*mm[7] - mm[1]*mm[6]);
		cof[8] = mm[0]*mm[4] - mm[1]*mm[3];
		d = mm[0]*cof[0] + mm[1]*cof[3] + mm[2]*cof[6];
		w.det = d[48:0];
		w.sing = (d == 0);
		w.sat = 1'b0;
		for (int k = 0; k < 9; k++) begin
			if (d == 0) begin
				w.inv[k] = '0;
			end else begin
				q = (cof[k] * (64'sd1 <<< 24)) / d;
				if (q > 64'sd2147483647) begin
					w.inv[k] = 32'h7FFFFFFF;
					w.sat = 1'b1;
				end else if (q < -64'sd2147483648) begin
					w.inv[k] = 32'h80000000;
					w.sat = 1'b1;
				end else begin
					w.inv[k] = q[31:0];
				end
			end
		end
		pending.push_back(w);
	endfunction

	// Compares one result word with the oldest expected word.
	function void check_result(inv_word_t got);
		inv_word_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result word", $realtime);
			errors++;
			return;
		end
		e = pending.pop_front();
		for (int k = 0; k < 9; k++)
			if (got.inv[k] !== e.inv[k]) begin
				$display("%0t: inv[%0d] expected %h actual %h", $realtime, k,
					e.inv[k], got.inv[k]);
				errors++;
			end
		if (got.det !== e.det) begin
			$display("%0t: determinant expected %h actual %h", $realtime, e.det, got.det);
			errors++;
		end
		if (got.sing !== e.sing) begin
			$display("%0t: singular expected %b actual %b", $realtime, e.sing, got.sing);
			errors++;
		end
		if (got.sat !== e.sat) begin
			$display("%0t: saturated expected %b actual %b", $realtime, e.sat, got.sat);
			errors++;
		end
	endfunction
endclass

module tb_matrix3x3_inverse_unit;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic stim_done = 1'b0;
	int   hold_cycles = 0;

	m3i_in_if  mat ();
	m3i_out_if res ();

	m3i_inverse_board board = new();

	matrix3x3_inverse_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.mat    (mat),
		.res    (res)
	);

	always #6 clk = ~clk;

	initial begin
		mat.valid = 1'b0;
		{mat.a00, mat.a01, mat.a02, mat.a10, mat.a11, mat.a12} = '0;
		{mat.a20, mat.a21, mat.a22} = '0;
		res.ready = 1'b0;
	end

	// Random entry, biased toward extremes, small values and full range.
	function automatic logic signed [15:0] pick_entry();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($signed($urandom_range(0, 1024)) - 512);
			3: return 16'sh0100;
			4: return 16'sh0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Sends one matrix word and waits until it is accepted.
	task automatic send_matrix(logic signed [15:0] m [9]);
		mat.valid <= 1'b1;
		mat.a00 <= m[0]; mat.a01 <= m[1]; mat.a02 <= m[2];
		mat.a10 <= m[3]; mat.a11 <= m[4]; mat.a12 <= m[5];
		mat.a20 <= m[6]; mat.a21 <= m[7]; mat.a22 <= m[8];
		do @(posedge clk); while (!mat.ready);
		board.note_matrix(m);
	endtask

	task automatic pause_input(int n);
		mat.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Stimulus: directed corner matrices, then random bursts.
	initial begin
		logic signed [15:0] m [9];
		int burst;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Identity, a scaled identity and the zero matrix.
		m = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100};
		send_matrix(m);
		m = '{16'sh0001, 0, 0, 0, 16'sh0001, 0, 0, 0, 16'sh0001};
		send_matrix(m);
		m = '{default: 16'sh0000};
		send_matrix(m);
		// All maximum and all minimum entries are singular.
		m = '{default: 16'sh7FFF};
		send_matrix(m);
		m = '{default: 16'sh8000};
		send_matrix(m);
		// Largest determinant terms; in the second matrix they nearly cancel.
		m = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
		send_matrix(m);
		m = '{16'sh7FFF, 16'sh8000, 0, 0, 16'sh7FFF, 16'sh8000, 16'sh8000, 0, 16'sh7FFF};
		send_matrix(m);
		m = '{16'sh7FFF, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh7FFF};
		send_matrix(m);
		// Negative permutation matrix and dependent rows.
		m = '{0, 16'shFF00, 0, 16'sh0100, 0, 0, 0, 0, 16'sh0100};
		send_matrix(m);
		m = '{16'sh0100, 16'sh0200, 16'sh0300, 16'sh0200, 16'sh0400, 16'sh0600,
			16'sh0001, 16'sh0002, 16'sh0007};
		send_matrix(m);
		// Tiny entries beside one large entry; the second inverse clips high and low.
		m = '{16'sh0001, 0, 0, 0, 16'sh0001, 16'sh7FFF, 0, 16'shFFFF, 16'sh0001};
		send_matrix(m);
		m = '{16'shFFFF, 16'sh0001, 0, 0, 16'sh0001, 0, 16'sh7FFF, 0, 16'sh0001};
		send_matrix(m);
		mat.valid <= 1'b0;
		@(posedge clk);
		// Random matrices in bursts with gaps; the receiver holds off once.
		for (int n = 0; n < 600; ) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && n < 600; b++, n++) begin
				if (n == 200) hold_cycles = 150;
				foreach (m[k]) m[k] = pick_entry();
				send_matrix(m);
			end
			if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 8));
		end
		mat.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: stalls on its own pattern, with a long hold-off on request.
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				res.ready <= 1'b0;
			end else begin
				mode = ($realtime / 3000.0) > 0 ? (int'($realtime) / 3000) % 3 : 0;
				case (mode)
					0: res.ready <= 1'b1;
					1: res.ready <= ($urandom_range(0, 3) != 0);
					default: res.ready <= ($urandom_range(0, 1) == 0);
				endcase
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		inv_word_t got;
		if (arst_n && res.valid && res.ready) begin
			got.inv = '{res.inv_00, res.inv_01, res.inv_02, res.inv_10, res.inv_11,
				res.inv_12, res.inv_20, res.inv_21, res.inv_22};
			got.det = res.determinant;
			got.sing = res.singular;
			got.sat = res.saturated;
			board.check_result(got);
		end
	end

	// End of run: drain the pipeline, then let trailing words show up.
	initial begin
		wait (stim_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0)
			$display("[matrix3x3_inverse_unit] OK");
		else
			$display("[matrix3x3_inverse_unit] ERROR");
		$finish;
	end

	initial begin
		#2ms;
		$display("[matrix3x3_inverse_unit] ERROR");
		$finish;
	end
endmodule

FILE: matrix3x3_inverse_unit.f
hdl/m3i_pkg.sv
hdl/m3i_if.sv
hdl/m3i_div.sv
hdl/matrix3x3_inverse_unit.sv
sim/tb_matrix3x3_inverse_unit.sv
